/* rtl/core/servo_pulse_sequence_generator_defines.svh */
// assertion helpers used by the checker file
`ifndef SERVO_PULSE_SEQUENCE_GENERATOR_DEFINES_SVH
`define SERVO_PULSE_SEQUENCE_GENERATOR_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define SPSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define SPSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/spsg_pkg.sv */
package spsg_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ANGLE_W   = 8;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOME      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PUSH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RETURN    = 3'd5;

    localparam logic [CFG_W-1:0] PERIOD_RST    = 16'd20000;
    localparam logic [CFG_W-1:0] PULSE_MIN_RST = 16'd450;
    localparam logic [CFG_W-1:0] PULSE_MAX_RST = 16'd2500;
    localparam logic [CFG_W-1:0] HOME_RST      = 16'd25;
    localparam logic [CFG_W-1:0] PUSH_RST      = 16'd150;
    localparam logic [CFG_W-1:0] RETURN_RST    = 16'd50;

    // request kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE = 8'd180;

    // angle * span / 180 is done as ((angle * span) >> 2) / 45 by reciprocal
    localparam int unsigned PROD_W      = ANGLE_W + CFG_W;
    localparam int unsigned SCALED_W    = PROD_W - 2;
    localparam int unsigned ANGLE_DIV   = 45;
    localparam int unsigned RECIP_SHIFT = 28;
    localparam int unsigned RECIP_W     = 23;
    localparam int unsigned QMUL_W      = SCALED_W + RECIP_W;
    localparam int unsigned RECIP_MULT  =
        ((32'd1 << RECIP_SHIFT) + ANGLE_DIV - 1) / ANGLE_DIV;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HOME   = 2'd1,
        PH_PUSH   = 2'd2,
        PH_RETURN = 2'd3
    } phase_t;

    typedef struct packed {
        logic               func;
        logic [ANGLE_W-1:0] angle;
    } in_item_t;

    typedef struct packed {
        logic   pin;
        logic   busy_res;
        phase_t phase;
        logic   sequence_done;
        logic   start_ignored;
    } out_item_t;

endpackage

/* rtl/core/servo_pulse_sequence_generator.sv */
// channel   direction   handshake              payload
// in        request in  in_valid / in_stall    in_data  (func, angle)
// out       result out  out_valid / out_stall  out_data (pin, busy_res, phase, done, ignored)
// cfg       write in    cfg_we                 cfg_index, cfg_data
//
// one request per clock while the result is not stalled; a taken request passes through
// the input register, product register and result register
// the angle * span product and the reciprocal multiply sit in separate stages
// reset returns the sequencer to idle and the configuration registers to their power-up values
// a stalled result holds; the two stages before it keep taking requests until full
module servo_pulse_sequence_generator
    import spsg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] period_reg;
    logic [CFG_W-1:0] pulse_min_reg;
    logic [CFG_W-1:0] pulse_max_reg;
    logic [CFG_W-1:0] home_reg;
    logic [CFG_W-1:0] push_reg;
    logic [CFG_W-1:0] return_reg;

    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              s2_valid_reg;
    logic              s2_func_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [PROD_W-1:0] s2_prod_next;

    logic out_adv;
    logic s2_free;
    logic s1_free;
    logic commit;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CFG_W-1:0] tick_reg;
    logic [CFG_W-1:0] tick_next;
    logic [CFG_W-1:0] periods_reg;
    logic [CFG_W-1:0] periods_next;
    logic [CFG_W-1:0] target_reg;
    logic [CFG_W-1:0] target_next;

    logic              out_valid_reg;
    out_item_t         out_data_reg;
    out_item_t         out_data_next;

    logic [ANGLE_W-1:0] angle_sat;
    logic [CFG_W-1:0]   span;
    logic [QMUL_W-1:0]  qmul;
    logic [CFG_W-1:0]   target_calc;
    logic [CFG_W:0]     tick_inc;
    logic [CFG_W-1:0]   period_eff;
    logic [CFG_W-1:0]   periods_inc;
    logic [CFG_W-1:0]   pulse_sel;

    function automatic logic [CFG_W-1:0] phase_count(
        input phase_t           ph,
        input logic [CFG_W-1:0] h,
        input logic [CFG_W-1:0] p,
        input logic [CFG_W-1:0] r
    );
        logic [CFG_W-1:0] cnt;
        unique case (ph)
            PH_HOME:   cnt = h;
            PH_PUSH:   cnt = p;
            PH_RETURN: cnt = r;
            default:   cnt = '0;
        endcase
        return cnt;
    endfunction

    // first phase at or after ph with a nonzero count, idle if none
    function automatic phase_t next_active(
        input phase_t           ph,
        input logic [CFG_W-1:0] h,
        input logic [CFG_W-1:0] p,
        input logic [CFG_W-1:0] r
    );
        phase_t res;
        unique case (ph)
            PH_HOME:
            begin
                if (h != '0)
                    res = PH_HOME;
                else if (p != '0)
                    res = PH_PUSH;
                else if (r != '0)
                    res = PH_RETURN;
                else
                    res = PH_IDLE;
            end
            PH_PUSH:
            begin
                if (p != '0)
                    res = PH_PUSH;
                else if (r != '0)
                    res = PH_RETURN;
                else
                    res = PH_IDLE;
            end
            PH_RETURN:
            begin
                res = (r != '0) ? PH_RETURN : PH_IDLE;
            end
            default:
            begin
                res = PH_IDLE;
            end
        endcase
        return res;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RST;
            pulse_min_reg <= PULSE_MIN_RST;
            pulse_max_reg <= PULSE_MAX_RST;
            home_reg      <= HOME_RST;
            push_reg      <= PUSH_RST;
            return_reg    <= RETURN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PERIOD:    period_reg    <= cfg_data;
                REG_PULSE_MIN: pulse_min_reg <= cfg_data;
                REG_PULSE_MAX: pulse_max_reg <= cfg_data;
                REG_HOME:      home_reg      <= cfg_data;
                REG_PUSH:      push_reg      <= cfg_data;
                REG_RETURN:    return_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // pipeline flow control
    assign out_adv  = !out_valid_reg || !out_stall;
    assign s2_free  = !s2_valid_reg || out_adv;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign commit   = s2_valid_reg && out_adv;
    assign in_stall = !s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= in_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_adv)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
            s1_item_reg <= in_data;
        if (s2_free)
        begin
            s2_func_reg <= s1_item_reg.func;
            s2_prod_reg <= s2_prod_next;
        end
        if (out_adv)
            out_data_reg <= out_data_next;
    end

    // stage one: saturated angle times pulse span
    always_comb
    begin
        angle_sat = (s1_item_reg.angle > MAX_ANGLE) ? MAX_ANGLE : s1_item_reg.angle;
        span      = (pulse_max_reg > pulse_min_reg) ? (pulse_max_reg - pulse_min_reg) : '0;
        s2_prod_next = PROD_W'(angle_sat) * PROD_W'(span);
    end

    // stage two: divide by 180, then the sequencer step
    always_comb
    begin
        qmul        = QMUL_W'(s2_prod_reg[PROD_W-1:2]) * QMUL_W'(RECIP_MULT);
        target_calc = pulse_min_reg + qmul[RECIP_SHIFT +: CFG_W];
    end

    // sequencer next state
    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        periods_next = periods_reg;
        target_next  = target_reg;
        period_eff   = (period_reg == '0) ? CFG_W'(1) : period_reg;
        tick_inc     = {1'b0, tick_reg} + 1'b1;
        periods_inc  = periods_reg + 1'b1;
        if (s2_func_reg == FUNC_START)
        begin
            if (phase_reg == PH_IDLE)
            begin
                target_next  = target_calc;
                tick_next    = '0;
                periods_next = '0;
                phase_next   = next_active(PH_HOME, home_reg, push_reg, return_reg);
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (tick_inc >= {1'b0, period_eff})
            begin
                tick_next = '0;
                if (periods_inc >= phase_count(phase_reg, home_reg, push_reg, return_reg))
                begin
                    periods_next = '0;
                    phase_next   = next_active(phase_t'(phase_reg + 2'd1),
                                               home_reg, push_reg, return_reg);
                end
                else
                begin
                    periods_next = periods_inc;
                end
            end
            else
            begin
                tick_next = tick_inc[CFG_W-1:0];
            end
        end
    end

    // result fields from the updated state
    always_comb
    begin
        pulse_sel = (phase_next == PH_PUSH) ? target_next : pulse_min_reg;
        out_data_next.pin      = (phase_next != PH_IDLE) && (tick_next < pulse_sel);
        out_data_next.busy_res = (phase_next != PH_IDLE);
        out_data_next.phase    = phase_next;
        out_data_next.start_ignored =
            (s2_func_reg == FUNC_START) && (phase_reg != PH_IDLE);
        // a sequence ends on a tick that leaves the last phase, or on a start
        // whose phases all have zero length
        out_data_next.sequence_done =
            (phase_next == PH_IDLE) &&
            (((s2_func_reg == FUNC_START) && (phase_reg == PH_IDLE)) ||
             ((s2_func_reg == FUNC_TICK) && (phase_reg != PH_IDLE)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            periods_reg <= '0;
            target_reg  <= '0;
        end
        else if (commit)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            periods_reg <= periods_next;
            target_reg  <= target_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/spsg_checker.sv */
`include "servo_pulse_sequence_generator_defines.svh"

module spsg_checker
    import spsg_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input out_item_t            out_data
);

    `SPSG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_data), "stalled result changed")

    `SPSG_ASSERT_NOW(a_busy_phase, clk, rst_n, out_valid,
        out_data.busy_res == (out_data.phase != PH_IDLE), "busy flag disagrees with phase")

    `SPSG_ASSERT_NOW(a_idle_pin_low, clk, rst_n, out_valid && (out_data.phase == PH_IDLE),
        !out_data.pin, "pin high while idle")

    `SPSG_ASSERT_NOW(a_done_idle, clk, rst_n, out_valid && out_data.sequence_done,
        (out_data.phase == PH_IDLE) && !out_data.start_ignored, "done while still running")

    `SPSG_ASSERT_NOW(a_ignored_busy, clk, rst_n, out_valid && out_data.start_ignored,
        out_data.busy_res, "start flagged as ignored while idle")

endmodule

bind servo_pulse_sequence_generator spsg_checker u_spsg_checker (.*);
